// ----- rtl/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared sizes, codes, word types and map helpers for the page allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

	localparam int PAGES          = 4096;
	localparam int RESERVED_PAGES = 256;
	localparam int RESV_EFF       = (RESERVED_PAGES > PAGES) ? PAGES : RESERVED_PAGES;

	localparam int PAGE_W = $clog2(PAGES);
	localparam int CNT_W  = PAGE_W + 1;
	localparam int WORD_W = 64;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int WORDS  = PAGES / WORD_W;
	localparam int ADDR_W = $clog2(WORDS);

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_RESERVE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BADPAR  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CNT_W-1:0]  page_count;
		logic [PAGE_W-1:0] page_index;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [PAGE_W-1:0] start_page;
		logic [CNT_W-1:0]  free_pages;
	} rsp_t;

	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] bit_pos;
		logic [CNT_W-1:0] run_out;
	} scan_res_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PAGE_W-1:0] lo;
		logic [PAGE_W-1:0] hi;
		logic              set;
	} mark_ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [BIT_W:0]    changed;
	} mark_res_t;

	// map word after reset: pages below the reserved count are used
	function automatic logic [WORD_W-1:0] init_word(input logic [ADDR_W-1:0] addr);
		logic [WORD_W-1:0] w;
		for (int b = 0; b < WORD_W; b++) begin
			w[b] = CNT_W'({addr, BIT_W'(b)}) < CNT_W'(RESV_EFF);
		end
		return w;
	endfunction

endpackage

// ----- rtl/first_fit_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_page_allocator_core
// First-fit contiguous page allocator over a used/free bitmap held in RAM,
// 64 pages per word, with a running free page count.
//
//   channel  dir  handshake           word
//   req      in   req_valid/req_stall  kind, page_count, page_index
//   rsp      out  rsp_valid/rsp_stall  status, start_page, free_pages
//
// After reset the map is written one word a cycle, req_stall high.
// Allocate: words scanned from word 0 up to the hit (up to 64), then words marked.
// Free/reserve: words touched are marked; rejected words go straight to the result.
// One RAM read and one write per cycle set the pace; one word in flight.
// A stalled result holds in the output register; the next word is taken
// once its result has been moved there.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffpa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffpa_pkg::rsp_t rsp
);
	import ffpa_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

	fsm_t              state_q, state_d;
	logic [1:0]        kind_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PAGE_W-1:0] lo_q;
	logic [PAGE_W-1:0] hi_q;
	logic [ADDR_W-1:0] cur_q;
	logic [CNT_W-1:0]  run_q;
	logic [CNT_W-1:0]  free_q;
	status_t           stat_q;
	logic [PAGE_W-1:0] start_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              accept;
	logic              is_alloc;
	logic              bad_req;
	logic              no_space;
	logic              range_bad;
	logic              go_scan;
	logic              go_mark;
	logic [PAGE_W-1:0] req_hi;
	logic [CNT_W:0]    req_end;
	logic [PAGE_W-1:0] hit_pos;
	logic [PAGE_W-1:0] alloc_lo;
	logic              rsp_free;

	logic              re, we;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [WORD_W-1:0] wdata, rdata;

	scan_res_t         scan;
	mark_ctl_t         mctl;
	mark_res_t         mres;

	ffpa_ram #(
		.DATA_W(WORD_W),
		.DEPTH (WORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	ffpa_scan u_scan (
		.used (rdata),
		.carry(run_q),
		.count(cnt_q),
		.res  (scan)
	);

	assign mctl = '{addr: cur_q, lo: lo_q, hi: hi_q, set: (kind_q != KIND_FREE)};

	ffpa_mark u_mark (
		.old_word(rdata),
		.ctl     (mctl),
		.res     (mres)
	);

	always_comb begin
		accept    = req_valid && !req_stall;
		is_alloc  = req.kind == KIND_ALLOC;
		bad_req   = (req.page_count == '0) ||
			!(req.kind inside {KIND_ALLOC, KIND_FREE, KIND_RESERVE});
		no_space  = (req.page_count > free_q) || (req.page_count > CNT_W'(PAGES));
		req_end   = (CNT_W + 1)'(req.page_index) + (CNT_W + 1)'(req.page_count);
		range_bad = req_end > (CNT_W + 1)'(PAGES);
		req_hi    = PAGE_W'(req_end - 1'b1);
		go_scan   = accept && !bad_req && is_alloc && !no_space;
		go_mark   = accept && !bad_req && !is_alloc && !range_bad;
		hit_pos   = {cur_q, scan.bit_pos};
		alloc_lo  = PAGE_W'(CNT_W'(hit_pos) + 1'b1 - cnt_q);
		rsp_free  = !rsp_valid_q || !rsp_stall;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (cur_q == LAST_WORD) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (go_scan) begin
					state_d = S_SCAN;
				end else if (go_mark) begin
					state_d = S_MARK;
				end else if (accept) begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (scan.hit) begin
					state_d = S_MARK;
				end else if (cur_q == LAST_WORD) begin
					state_d = S_DONE;
				end
			end
			S_MARK: begin
				if (cur_q == hi_q[PAGE_W-1:BIT_W]) state_d = S_DONE;
			end
			S_DONE: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	// outputs and map port control
	always_comb begin
		req_stall = state_q != S_IDLE;
		re        = 1'b0;
		raddr     = cur_q;
		we        = 1'b0;
		waddr     = cur_q;
		wdata     = mres.word;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				wdata = init_word(cur_q);
			end
			S_IDLE: begin
				if (go_scan) begin
					re    = 1'b1;
					raddr = '0;
				end else if (go_mark) begin
					re    = 1'b1;
					raddr = req.page_index[PAGE_W-1:BIT_W];
				end
			end
			S_SCAN: begin
				if (scan.hit) begin
					re    = 1'b1;
					raddr = alloc_lo[PAGE_W-1:BIT_W];
				end else if (cur_q != LAST_WORD) begin
					re    = 1'b1;
					raddr = cur_q + 1'b1;
				end
			end
			S_MARK: begin
				we = 1'b1;
				if (cur_q != hi_q[PAGE_W-1:BIT_W]) begin
					re    = 1'b1;
					raddr = cur_q + 1'b1;
				end
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cur_q       <= '0;
			free_q      <= CNT_W'(PAGES - RESV_EFF);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) begin
				cur_q <= (cur_q == LAST_WORD) ? '0 : cur_q + 1'b1;
			end else if (re) begin
				cur_q <= raddr;
			end
			if (state_q == S_MARK) begin
				free_q <= mctl.set ? free_q - CNT_W'(mres.changed)
					: free_q + CNT_W'(mres.changed);
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			kind_q  <= req.kind;
			cnt_q   <= req.page_count;
			run_q   <= '0;
			start_q <= '0;
			lo_q    <= req.page_index;
			hi_q    <= req_hi;
			if (bad_req) begin
				stat_q <= ST_BADPAR;
			end else if (is_alloc) begin
				stat_q <= no_space ? ST_NOSPACE : ST_OK;
			end else begin
				stat_q <= range_bad ? ST_BADPAR : ST_OK;
			end
		end
		if (state_q == S_SCAN) begin
			run_q <= scan.run_out;
			if (scan.hit) begin
				lo_q    <= alloc_lo;
				hi_q    <= hit_pos;
				start_q <= alloc_lo;
			end else if (cur_q == LAST_WORD) begin
				stat_q <= ST_NOSPACE;
			end
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.status     <= stat_q;
			rsp_q.start_page <= start_q;
			rsp_q.free_pages <= free_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (waddr != raddr))
		else $error("map read and write hit the same word");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(PAGES))
		else $error("free page count above map size");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (cur_q <= hi_q[PAGE_W-1:BIT_W]))
		else $error("mark pass beyond last run word");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !scan.hit && cur_q == LAST_WORD) |=> (state_q == S_DONE))
		else $error("scan did not end at last map word");

endmodule

// ----- rtl/ffpa_ram.sv -----
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffpa_ram #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/ffpa_scan.sv -----
// ----------------------------------------------------------------------------
// ffpa_scan
// First-fit search over one map word: free run length at each bit, carried
// in from lower words, and the lowest bit where the run reaches the count.
// ----------------------------------------------------------------------------
module ffpa_scan (
	input  logic [ffpa_pkg::WORD_W-1:0] used,
	input  logic [ffpa_pkg::CNT_W-1:0]  carry,
	input  logic [ffpa_pkg::CNT_W-1:0]  count,
	output ffpa_pkg::scan_res_t         res
);
	import ffpa_pkg::*;

	// {valid, position} of the nearest used bit at or below each bit
	logic [BIT_W:0]    lu [BIT_W+1][WORD_W];
	logic [CNT_W-1:0]  run [WORD_W];
	logic [WORD_W-1:0] hit;

	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			lu[0][b] = used[b] ? {1'b1, BIT_W'(b)} : '0;
		end
		for (int s = 0; s < BIT_W; s++) begin
			for (int b = 0; b < WORD_W; b++) begin
				if (b >= (1 << s) && !lu[s][b][BIT_W]) begin
					lu[s+1][b] = lu[s][b - (1 << s)];
				end else begin
					lu[s+1][b] = lu[s][b];
				end
			end
		end
		for (int b = 0; b < WORD_W; b++) begin
			if (lu[BIT_W][b][BIT_W]) begin
				run[b] = CNT_W'(BIT_W'(b) - lu[BIT_W][b][BIT_W-1:0]);
			end else begin
				run[b] = carry + CNT_W'(b + 1);
			end
			hit[b] = run[b] >= count;
		end
		res.hit     = |hit;
		res.bit_pos = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (hit[b]) begin
				res.bit_pos = BIT_W'(b);
			end
		end
		res.run_out = run[WORD_W-1];
	end

endmodule

// ----- rtl/ffpa_mark.sv -----
// ----------------------------------------------------------------------------
// ffpa_mark
// Word update for a run mark: builds the run mask for one map word, sets or
// clears it and counts the marks that actually change.
// ----------------------------------------------------------------------------
module ffpa_mark (
	input  logic [ffpa_pkg::WORD_W-1:0] old_word,
	input  ffpa_pkg::mark_ctl_t         ctl,
	output ffpa_pkg::mark_res_t         res
);
	import ffpa_pkg::*;

	logic [BIT_W-1:0]  lo_bit;
	logic [BIT_W-1:0]  hi_bit;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] flip;

	always_comb begin
		lo_bit = (ctl.addr == ctl.lo[PAGE_W-1:BIT_W]) ? ctl.lo[BIT_W-1:0] : '0;
		hi_bit = (ctl.addr == ctl.hi[PAGE_W-1:BIT_W]) ? ctl.hi[BIT_W-1:0] : '1;
		mask   = ({WORD_W{1'b1}} << lo_bit) &
			({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit));
		flip   = ctl.set ? (~old_word & mask) : (old_word & mask);
		res.word    = old_word ^ flip;
		res.changed = (BIT_W + 1)'($countones(flip));
	end

endmodule
